[design/mrar_pkg.sv]
// Shared types, constants and arithmetic helpers for the medium room reverb.
`default_nettype none
package mrar_pkg;

    localparam int CFG_IDX_BITS = 3;
    localparam int COEF_BITS    = 24;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LPF_B0 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LPF_B1 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LPF_B2 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LPF_A1 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LPF_A2 = 3'd4;

    localparam logic signed [COEF_BITS-1:0] LPF_B0_RST = 24'sd105596;
    localparam logic signed [COEF_BITS-1:0] LPF_B1_RST = 24'sd211193;
    localparam logic signed [COEF_BITS-1:0] LPF_B2_RST = 24'sd105596;
    localparam logic signed [COEF_BITS-1:0] LPF_A1_RST = -24'sd6306955;
    localparam logic signed [COEF_BITS-1:0] LPF_A2_RST = 24'sd2535037;

    // Q2.22 gains
    localparam logic signed [COEF_BITS-1:0] G_025 = 24'sd1048576;
    localparam logic signed [COEF_BITS-1:0] G_035 = 24'sd1468006;
    localparam logic signed [COEF_BITS-1:0] G_045 = 24'sd1887437;
    localparam logic signed [COEF_BITS-1:0] G_040 = 24'sd1677722;

    // Allpass section numbers after which the sequence branches, and the section it resumes at after the premix
    localparam logic [2:0] SEC_TAP35   = 3'd2;
    localparam logic [2:0] SEC_TAP137  = 3'd3;
    localparam logic [2:0] SEC_PREMIX  = 3'd4;
    localparam logic [2:0] SEC_TAP191  = 3'd5;

    localparam logic [1:0] TAP_35  = 2'd0;
    localparam logic [1:0] TAP_137 = 2'd1;
    localparam logic [1:0] TAP_191 = 2'd2;

    typedef enum logic [4:0] {
        ST_CLR, ST_IDLE, ST_WDRY, ST_MA1, ST_MA2, ST_W, ST_MB0, ST_MB1, ST_MB2,
        ST_Y, ST_MFB, ST_WFB, ST_AP_RA, ST_AP_RB, ST_AP_M1, ST_AP_T, ST_AP_M2,
        ST_AP_WA, ST_AP_WB, ST_TAP_RD, ST_TAP_ACC, ST_PR_RA, ST_PR_RB, ST_PR_M,
        ST_PR_W, ST_DONE
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP, DP_CLR, DP_START, DP_WDRY, DP_MA1, DP_MA2, DP_W, DP_MB0, DP_MB1,
        DP_MB2, DP_Y, DP_MFB, DP_WFB, DP_AP_RA, DP_AP_RB, DP_AP_M1, DP_AP_T,
        DP_AP_M2, DP_AP_WA, DP_AP_WB, DP_TAP_RD, DP_TAP_ACC, DP_PR_RA, DP_PR_RB,
        DP_PR_M, DP_PR_W, DP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [2:0] sec;
        logic [1:0] tap;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
    } t_dp_status;

    // Round half up and drop 22 fraction bits.
    function automatic logic signed [35:0] f_qround(input logic signed [57:0] v);
        logic signed [57:0] s;
        s = v + 58'sd2097152;
        return 36'(s >>> 22);
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -40'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

endpackage
`default_nettype wire

[design/mrar_ctrl.sv]
// Sequencer that clears the delay memory after reset and steps the reverb datapath through one sample.
`default_nettype none
module mrar_ctrl
    import mrar_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_status i_stat,
    output t_dp_cmd         o_cmd
);

    t_state     r_state, n_state;
    logic [2:0] r_sec, n_sec;
    logic [1:0] r_tap, n_tap;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_sec       <= '0;
            r_tap       <= TAP_35;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sec       <= n_sec;
            r_tap       <= n_tap;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sec       = r_sec;
        n_tap       = r_tap;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd.op    = DP_NOP;
        o_cmd.sec   = r_sec;
        o_cmd.tap   = r_tap;
        unique case (r_state)
            ST_CLR: begin
                o_cmd.op = DP_CLR;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = DP_START;
                    n_state  = ST_WDRY;
                end
            end
            ST_WDRY: begin o_cmd.op = DP_WDRY; n_state = ST_MA1; end
            ST_MA1:  begin o_cmd.op = DP_MA1;  n_state = ST_MA2; end
            ST_MA2:  begin o_cmd.op = DP_MA2;  n_state = ST_W;   end
            ST_W:    begin o_cmd.op = DP_W;    n_state = ST_MB0; end
            ST_MB0:  begin o_cmd.op = DP_MB0;  n_state = ST_MB1; end
            ST_MB1:  begin o_cmd.op = DP_MB1;  n_state = ST_MB2; end
            ST_MB2:  begin o_cmd.op = DP_MB2;  n_state = ST_Y;   end
            ST_Y:    begin o_cmd.op = DP_Y;    n_state = ST_MFB; end
            ST_MFB:  begin o_cmd.op = DP_MFB;  n_state = ST_WFB; end
            ST_WFB: begin
                o_cmd.op = DP_WFB;
                n_sec    = '0;
                n_state  = ST_AP_RA;
            end
            ST_AP_RA: begin o_cmd.op = DP_AP_RA; n_state = ST_AP_RB; end
            ST_AP_RB: begin o_cmd.op = DP_AP_RB; n_state = ST_AP_M1; end
            ST_AP_M1: begin o_cmd.op = DP_AP_M1; n_state = ST_AP_T;  end
            ST_AP_T:  begin o_cmd.op = DP_AP_T;  n_state = ST_AP_M2; end
            ST_AP_M2: begin o_cmd.op = DP_AP_M2; n_state = ST_AP_WA; end
            ST_AP_WA: begin o_cmd.op = DP_AP_WA; n_state = ST_AP_WB; end
            ST_AP_WB: begin
                o_cmd.op = DP_AP_WB;
                if (r_sec == SEC_TAP35) begin
                    n_tap   = TAP_35;
                    n_state = ST_TAP_RD;
                end else if (r_sec == SEC_TAP137) begin
                    n_tap   = TAP_137;
                    n_state = ST_TAP_RD;
                end else if (r_sec == SEC_TAP191) begin
                    n_tap   = TAP_191;
                    n_state = ST_TAP_RD;
                end else begin
                    n_sec   = r_sec + 3'd1;
                    n_state = ST_AP_RA;
                end
            end
            ST_TAP_RD: begin o_cmd.op = DP_TAP_RD; n_state = ST_TAP_ACC; end
            ST_TAP_ACC: begin
                o_cmd.op = DP_TAP_ACC;
                if (r_tap == TAP_35) begin
                    n_sec   = r_sec + 3'd1;
                    n_state = ST_AP_RA;
                end else if (r_tap == TAP_137) begin
                    n_state = ST_PR_RA;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_PR_RA: begin o_cmd.op = DP_PR_RA; n_state = ST_PR_RB; end
            ST_PR_RB: begin o_cmd.op = DP_PR_RB; n_state = ST_PR_M;  end
            ST_PR_M:  begin o_cmd.op = DP_PR_M;  n_state = ST_PR_W;  end
            ST_PR_W: begin
                o_cmd.op = DP_PR_W;
                n_sec    = SEC_PREMIX;
                n_state  = ST_AP_RA;
            end
            ST_DONE: begin
                // wait until the output register is free, then load it
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = DP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

[design/mrar_dp.sv]
// Datapath of the reverb: delay memory, shared multiplier, filter and allpass arithmetic.
`default_nettype none
module mrar_dp
    import mrar_pkg::*;
#(
    parameter int SAMPLES_PER_MS = 44,
    parameter int DELAY_DEPTH    = 13156,
    parameter int SAMPLE_BITS    = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_dp_cmd                       i_cmd,
    output t_dp_status                         o_stat,
    input  wire logic signed [SAMPLE_BITS-1:0] i_dry,
    output logic signed [SAMPLE_BITS-1:0]      o_wet,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  wire logic [COEF_BITS-1:0]          i_cfg_data
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW+1)'(DELAY_DEPTH);
    localparam logic [AW:0] OFF_2    = (AW+1)'((2 * SAMPLES_PER_MS) % DELAY_DEPTH);
    localparam logic [AW:0] OFF_3    = (AW+1)'((3 * SAMPLES_PER_MS) % DELAY_DEPTH);
    localparam logic [AW:0] OFF_10_3 = (AW+1)'(((103 * SAMPLES_PER_MS) / 10) % DELAY_DEPTH);
    localparam logic [AW:0] OFF_25   = (AW+1)'((25 * SAMPLES_PER_MS) % DELAY_DEPTH);
    localparam logic [AW:0] OFF_35   = (AW+1)'((35 * SAMPLES_PER_MS) % DELAY_DEPTH);
    localparam logic [AW:0] OFF_40   = (AW+1)'((40 * SAMPLES_PER_MS) % DELAY_DEPTH);
    localparam logic [AW:0] OFF_70   = (AW+1)'((70 * SAMPLES_PER_MS) % DELAY_DEPTH);
    localparam logic [AW:0] OFF_137  = (AW+1)'((137 * SAMPLES_PER_MS) % DELAY_DEPTH);
    localparam logic [AW:0] OFF_152  = (AW+1)'((152 * SAMPLES_PER_MS) % DELAY_DEPTH);
    localparam logic [AW:0] OFF_153  = (AW+1)'((153 * SAMPLES_PER_MS) % DELAY_DEPTH);
    localparam logic [AW:0] OFF_162_8 =
        (AW+1)'(((1628 * SAMPLES_PER_MS) / 10) % DELAY_DEPTH);
    localparam logic [AW:0] OFF_191  = (AW+1)'((191 * SAMPLES_PER_MS) % DELAY_DEPTH);
    localparam logic signed [33:0] OUT_MAX = (34'sd1 <<< (SAMPLE_BITS - 1)) - 34'sd1;
    localparam logic signed [33:0] OUT_MIN = -OUT_MAX - 34'sd1;

    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] p, input logic [AW:0] off);
        logic [AW:0] s;
        s = {1'b0, p} + off;
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    logic signed [31:0] r_mem [DELAY_DEPTH];
    logic signed [31:0] r_q;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic signed [31:0] mem_wdata;

    logic [AW-1:0]      r_clr, r_wp, r_pp;
    logic signed [SAMPLE_BITS-1:0] r_dry, r_wet;
    logic signed [31:0] r_a, r_b, r_t, r_w, r_w1, r_w2;
    logic signed [55:0] r_prod;
    logic signed [57:0] r_acc;
    logic signed [33:0] r_sum;
    logic signed [COEF_BITS-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;

    logic signed [31:0]          mul_a;
    logic signed [COEF_BITS-1:0] mul_b, gain;
    logic signed [55:0]          mul_p;
    logic [AW:0]                 ia_off, ib_off, tap_off;
    logic [AW-1:0]               ia, ib, tap_addr, p152;
    logic signed [35:0]          prod_rnd, sum_rnd;
    logic signed [57:0]          acc_sum;
    logic signed [33:0]          half;

    // Allpass section table and tap offsets
    always_comb begin
        case (i_cmd.sec)
            3'd0:    begin ia_off = '0;      ib_off = OFF_35;    gain = G_025; end
            3'd1:    begin ia_off = OFF_2;   ib_off = OFF_10_3;  gain = G_035; end
            3'd2:    begin ia_off = OFF_3;   ib_off = OFF_25;    gain = G_045; end
            3'd3:    begin ia_off = OFF_40;  ib_off = OFF_70;    gain = G_045; end
            3'd4:    begin ia_off = OFF_152; ib_off = OFF_191;   gain = G_025; end
            default: begin ia_off = OFF_153; ib_off = OFF_162_8; gain = G_035; end
        endcase
        case (i_cmd.tap)
            TAP_35:  tap_off = OFF_35;
            TAP_137: tap_off = OFF_137;
            default: tap_off = OFF_191;
        endcase
    end

    assign ia       = f_wrap(r_wp, ia_off);
    assign ib       = f_wrap(r_wp, ib_off);
    assign tap_addr = f_wrap(r_wp, tap_off);
    assign p152     = f_wrap(r_wp, OFF_152);
    assign mul_p    = mul_a * mul_b;
    assign prod_rnd = f_qround(58'(r_prod));
    assign acc_sum  = r_acc + 58'(r_prod);
    assign sum_rnd  = f_qround(acc_sum);
    assign half     = (r_sum + 34'sd1) >>> 1;

    always_comb begin
        mul_a     = r_a;
        mul_b     = '0;
        mem_we    = 1'b0;
        mem_waddr = r_wp;
        mem_wdata = '0;
        mem_raddr = r_wp;
        unique case (i_cmd.op)
            DP_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
            end
            DP_WDRY: begin
                mem_we    = 1'b1;
                mem_wdata = 32'(r_dry);
                mem_raddr = r_pp;
            end
            DP_MA1:   begin mul_a = r_w1; mul_b = r_a1; end
            DP_MA2:   begin mul_a = r_w2; mul_b = r_a2; end
            DP_MB0:   begin mul_a = r_w;  mul_b = r_b0; end
            DP_MB1:   begin mul_a = r_w1; mul_b = r_b1; end
            DP_MB2:   begin mul_a = r_w2; mul_b = r_b2; end
            DP_MFB:   begin mul_a = r_t;  mul_b = G_040; end
            DP_WFB: begin
                mem_we    = 1'b1;
                mem_wdata = f_sat32(40'(r_b) + 40'(prod_rnd));
            end
            DP_AP_RA: mem_raddr = ia;
            DP_AP_RB: mem_raddr = ib;
            DP_AP_M1: begin mul_a = r_a; mul_b = gain; end
            DP_AP_M2: begin mul_a = r_t; mul_b = gain; end
            DP_AP_WA: begin
                mem_we    = 1'b1;
                mem_waddr = ia;
                mem_wdata = f_sat32(40'(r_a) + 40'(prod_rnd));
            end
            DP_AP_WB: begin
                mem_we    = 1'b1;
                mem_waddr = ib;
                mem_wdata = r_t;
            end
            DP_TAP_RD: mem_raddr = tap_addr;
            DP_PR_RA:  mem_raddr = p152;
            DP_PR_M:   begin mul_a = r_a; mul_b = G_040; end
            DP_PR_W: begin
                mem_we    = 1'b1;
                mem_waddr = p152;
                mem_wdata = f_sat32(40'(prod_rnd) + 40'(r_b));
            end
            default: ;
        endcase
    end

    // Delay memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_q <= r_mem[mem_raddr];
    end

    // Control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_wp  <= '0;
            r_pp  <= '0;
            r_w1  <= '0;
            r_w2  <= '0;
            r_b0  <= LPF_B0_RST;
            r_b1  <= LPF_B1_RST;
            r_b2  <= LPF_B2_RST;
            r_a1  <= LPF_A1_RST;
            r_a2  <= LPF_A2_RST;
        end else begin
            if (i_cmd.op == DP_CLR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.op == DP_START) begin
                r_pp <= r_wp;
                r_wp <= (r_wp == AW'(DELAY_DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_cmd.op == DP_Y) begin
                r_w2 <= r_w1;
                r_w1 <= r_w;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LPF_B0: r_b0 <= i_cfg_data;
                    CFG_LPF_B1: r_b1 <= i_cfg_data;
                    CFG_LPF_B2: r_b2 <= i_cfg_data;
                    CFG_LPF_A1: r_a1 <= i_cfg_data;
                    CFG_LPF_A2: r_a2 <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Arithmetic registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (i_cmd.op)
            DP_START:   begin r_dry <= i_dry; r_sum <= '0; end
            DP_MA1:     r_a <= r_q;
            DP_MA2:     r_acc <= 58'(r_prod);
            DP_W:       r_w <= f_sat32(40'(r_a) - 40'(sum_rnd));
            DP_MB1:     r_acc <= 58'(r_prod);
            DP_MB2:     r_acc <= acc_sum;
            DP_Y:       r_t <= f_sat32(40'(sum_rnd));
            DP_MFB:     r_b <= r_q;
            DP_AP_RB:   r_a <= r_q;
            DP_AP_M1:   r_b <= r_q;
            DP_AP_T:    r_t <= f_sat32(40'(r_b) - 40'(prod_rnd));
            DP_TAP_ACC: r_sum <= r_sum + 34'(r_q);
            DP_PR_RB:   r_a <= r_q;
            DP_PR_M:    r_b <= r_q;
            DP_OUT: begin
                if (half > OUT_MAX) begin
                    r_wet <= OUT_MAX[SAMPLE_BITS-1:0];
                end else if (half < OUT_MIN) begin
                    r_wet <= OUT_MIN[SAMPLE_BITS-1:0];
                end else begin
                    r_wet <= half[SAMPLE_BITS-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_stat.clr_last = (r_clr == AW'(DELAY_DEPTH - 1));
    assign o_wet           = r_wet;

endmodule
`default_nettype wire

[design/medium_room_allpass_reverb.sv]
// Top level of the medium room allpass reverberator.
//
//  Channel   Direction  Ports              Payload
//  s_axis    in         tvalid/tready      tdata: dry_sample (signed), zero padded
//  m_axis    out        tvalid/tready      tdata: wet_sample (signed), zero padded
//  cfg       in         valid/ready        index: register 0..4, data: 24-bit coefficient
//
//  One sample is worked through from transfer in to result load before the next is taken:
//  the sequence is bound by the single read and single write port of the delay memory
//  and the one shared 24 x 32 multiplier, which every filter and allpass multiplication
//  goes through in turn.
//  After reset the delay memory is cleared one word a cycle, all DELAY_DEPTH words,
//  with s_axis tready low; cfg transfers are taken at any time.
//  A finished result waits in the output register; the next sample is accepted
//  meanwhile and holds in its final step until that register is taken.
`default_nettype none
module medium_room_allpass_reverb
    import mrar_pkg::*;
#(
    parameter int SAMPLES_PER_MS = 44,
    parameter int DELAY_DEPTH    = 13156,
    parameter int SAMPLE_BITS    = 24
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    // dry_sample
    input  wire logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] i_s_axis_tdata,
    output logic                                       o_m_axis_tvalid,
    input  wire logic                                  i_m_axis_tready,
    // wet_sample
    output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0]      o_m_axis_tdata,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]               i_cfg_index,
    input  wire logic [COEF_BITS-1:0]                  i_cfg_data
);

    localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8;

    t_dp_cmd                       cmd;
    t_dp_status                    stat;
    logic signed [SAMPLE_BITS-1:0] wet;

    // Coefficient writes never stall.
    assign o_cfg_ready = 1'b1;

    mrar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mrar_dp #(
        .SAMPLES_PER_MS (SAMPLES_PER_MS),
        .DELAY_DEPTH    (DELAY_DEPTH),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_dry       (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_wet       (wet),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Zero pad the sample up to whole bytes.
    assign o_m_axis_tdata = TDW'($unsigned(wet));

`ifndef SYNTH
    // The clearing pass keeps the input closed right after reset.
    a_clear_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_s_axis_tready)
        else $error("input open during memory clear");

    // Only one sample is in flight.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second sample accepted while busy");

    // A result appears only from the last step, never from idle.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(o_s_axis_tready))
        else $error("result loaded without a sample in work");
`endif

endmodule
`default_nettype wire
